### design/ibb_pkg.sv
`timescale 1ns / 1ps
package ibb_pkg;

  localparam int MAX_SRC_WIDTH  = 4096;
  localparam int MAX_OUT_WIDTH  = 1024;
  localparam int MAX_GRID       = 16;
  localparam int MAX_OUT_HEIGHT = 1024;

  localparam int PIX_W     = 16;
  localparam int SUM_W     = 24;
  localparam int NUM_W     = SUM_W + 1;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;

  localparam int SRC_WIDTH_W  = 13;
  localparam int OUT_WIDTH_W  = 11;
  localparam int OUT_HEIGHT_W = 11;
  localparam int GRID_W       = 5;

  localparam logic [2:0] REG_SRC_WIDTH   = 3'd0;
  localparam logic [2:0] REG_OUT_WIDTH   = 3'd1;
  localparam logic [2:0] REG_OUT_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_GRID_WIDTH  = 3'd3;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd4;
  localparam logic [2:0] REG_SUM_MODE    = 3'd5;

  typedef struct packed {
    logic accept;
    logic acc_en;
    logic div_step;
    logic out_load;
  } ibb_cmd_t;

  typedef struct packed {
    logic in_range;
    logic complete;
    logic sum_mode;
    logic out_free;
  } ibb_stat_t;

endpackage

### design/ibb_ctrl.sv
`timescale 1ns / 1ps
module ibb_ctrl
  import ibb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  ibb_stat_t stat_i,
  output ibb_cmd_t  cmd_o,
  output logic      in_stall_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACC  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] step_q, step_d;

  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    cmd_o         = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && stat_i.in_range) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc_en = 1'b1;
        step_d       = '0;
        if (!stat_i.complete) begin
          state_d = S_IDLE;
        end else if (stat_i.sum_mode) begin
          state_d = S_OUT;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == DIV_CNT_W'(NUM_W - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.out_free) else $error("output overwritten");
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> step_q < DIV_CNT_W'(NUM_W)) else $error("divide overrun");
  a_acc_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && stat_i.in_range) |=> state_q == S_ACC)
    else $error("accumulate skipped");

endmodule

### design/ibb_datapath.sv
`timescale 1ns / 1ps
module ibb_datapath
  import ibb_pkg::*;
#(
  parameter int MaxSrcWidth = MAX_SRC_WIDTH,
  parameter int MaxOutWidth = MAX_OUT_WIDTH,
  parameter int MaxGrid     = MAX_GRID
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  input  logic [PIX_W-1:0]   pixel_i,
  input  logic               frame_start_i,
  input  logic               out_stall_i,
  output logic [PIX_W-1:0]   out_pixel_o,
  output logic               out_last_o,
  output logic               out_valid_o,
  input  ibb_cmd_t           cmd_i,
  output ibb_stat_t          stat_o
);

  localparam int SCW  = $clog2(MaxSrcWidth + 1);
  localparam int OCW  = $clog2(MaxOutWidth + 1);
  localparam int ORW  = $clog2(MAX_OUT_HEIGHT + 1);
  localparam int PHW  = $clog2(MaxGrid + 1);
  localparam int IDXW = (MaxOutWidth > 1) ? $clog2(MaxOutWidth) : 1;
  localparam int CNTW = $clog2(MaxGrid * MaxGrid + 1);

  logic [SRC_WIDTH_W-1:0]  src_width_q;
  logic [OUT_WIDTH_W-1:0]  out_width_q;
  logic [OUT_HEIGHT_W-1:0] out_height_q;
  logic [GRID_W-1:0]       grid_width_q, grid_height_q;
  logic                    sum_mode_q;
  logic                    wr_en;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q   <= SRC_WIDTH_W'(1024);
      out_width_q   <= OUT_WIDTH_W'(512);
      out_height_q  <= OUT_HEIGHT_W'(512);
      grid_width_q  <= GRID_W'(2);
      grid_height_q <= GRID_W'(2);
      sum_mode_q    <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_SRC_WIDTH:   src_width_q   <= pwdata[SRC_WIDTH_W-1:0];
        REG_OUT_WIDTH:   out_width_q   <= pwdata[OUT_WIDTH_W-1:0];
        REG_OUT_HEIGHT:  out_height_q  <= pwdata[OUT_HEIGHT_W-1:0];
        REG_GRID_WIDTH:  grid_width_q  <= pwdata[GRID_W-1:0];
        REG_GRID_HEIGHT: grid_height_q <= pwdata[GRID_W-1:0];
        REG_SUM_MODE:    sum_mode_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_SRC_WIDTH:   prdata = PDATA_W'(src_width_q);
      REG_OUT_WIDTH:   prdata = PDATA_W'(out_width_q);
      REG_OUT_HEIGHT:  prdata = PDATA_W'(out_height_q);
      REG_GRID_WIDTH:  prdata = PDATA_W'(grid_width_q);
      REG_GRID_HEIGHT: prdata = PDATA_W'(grid_height_q);
      REG_SUM_MODE:    prdata = PDATA_W'(sum_mode_q);
      default:         prdata = '0;
    endcase
  end

  // clamped configuration
  logic [31:0] sw32, ow32, oh32, gw32, gh32;
  logic [SCW-1:0] sw;
  logic [OCW-1:0] ow;
  logic [ORW-1:0] oh;
  logic [PHW-1:0] gw, gh;

  always_comb begin
    sw32 = 32'(src_width_q);
    ow32 = 32'(out_width_q);
    oh32 = 32'(out_height_q);
    gw32 = 32'(grid_width_q);
    gh32 = 32'(grid_height_q);
    if (sw32 == 32'd0) sw32 = 32'd1;
    else if (sw32 > 32'(MaxSrcWidth)) sw32 = 32'(MaxSrcWidth);
    if (ow32 == 32'd0) ow32 = 32'd1;
    else if (ow32 > 32'(MaxOutWidth)) ow32 = 32'(MaxOutWidth);
    if (oh32 == 32'd0) oh32 = 32'd1;
    else if (oh32 > 32'(MAX_OUT_HEIGHT)) oh32 = 32'(MAX_OUT_HEIGHT);
    if (gw32 == 32'd0) gw32 = 32'd1;
    else if (gw32 > 32'(MaxGrid)) gw32 = 32'(MaxGrid);
    if (gh32 == 32'd0) gh32 = 32'd1;
    else if (gh32 > 32'(MaxGrid)) gh32 = 32'(MaxGrid);
  end

  assign sw = sw32[SCW-1:0];
  assign ow = ow32[OCW-1:0];
  assign oh = oh32[ORW-1:0];
  assign gw = gw32[PHW-1:0];
  assign gh = gh32[PHW-1:0];

  // position counters
  logic [SCW-1:0] src_col_q, src_col_d, sc_e;
  logic [PHW-1:0] gcp_q, gcp_d, gcp_e, grp_q, grp_d, grp_e;
  logic [OCW-1:0] out_col_q, out_col_d, oc_e;
  logic [ORW-1:0] out_row_q, out_row_d, or_e;
  logic [SCW:0]   sc_inc;
  logic [PHW:0]   gcp_inc, grp_inc;
  logic           in_range, complete, last;

  always_comb begin
    sc_e  = frame_start_i ? '0 : src_col_q;
    gcp_e = frame_start_i ? '0 : gcp_q;
    grp_e = frame_start_i ? '0 : grp_q;
    oc_e  = frame_start_i ? '0 : out_col_q;
    or_e  = frame_start_i ? '0 : out_row_q;

    sc_inc  = {1'b0, sc_e} + 1'b1;
    gcp_inc = {1'b0, gcp_e} + 1'b1;
    grp_inc = {1'b0, grp_e} + 1'b1;

    in_range = (or_e < oh) && (oc_e < ow);
    complete = (gcp_inc >= {1'b0, gw}) && (grp_inc >= {1'b0, gh});
    last     = (({1'b0, oc_e} + 1'b1) == {1'b0, ow}) &&
               (({1'b0, or_e} + 1'b1) == {1'b0, oh});

    src_col_d = sc_e;
    gcp_d     = gcp_e;
    grp_d     = grp_e;
    out_col_d = oc_e;
    out_row_d = or_e;
    if (sc_inc >= {1'b0, sw}) begin
      src_col_d = '0;
      gcp_d     = '0;
      out_col_d = '0;
      if (grp_inc >= {1'b0, gh}) begin
        grp_d = '0;
        if (or_e < oh) out_row_d = or_e + 1'b1;
      end else begin
        grp_d = grp_inc[PHW-1:0];
      end
    end else begin
      src_col_d = sc_inc[SCW-1:0];
      if (gcp_inc >= {1'b0, gw}) begin
        gcp_d = '0;
        if (oc_e < ow) out_col_d = oc_e + 1'b1;
      end else begin
        gcp_d = gcp_inc[PHW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      gcp_q     <= '0;
      grp_q     <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (cmd_i.accept) begin
      src_col_q <= src_col_d;
      gcp_q     <= gcp_d;
      grp_q     <= grp_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // column accumulators
  logic [SUM_W-1:0] col_mem [MaxOutWidth];
  logic [SUM_W-1:0] rd_q, acc_d;
  logic [IDXW-1:0]  idx_q;
  logic [PIX_W-1:0] pix_q;
  logic             first_q, complete_q, last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q       <= col_mem[oc_e[IDXW-1:0]];
      idx_q      <= oc_e[IDXW-1:0];
      pix_q      <= pixel_i;
      first_q    <= (gcp_e == '0) && (grp_e == '0);
      complete_q <= complete;
      last_q     <= last;
    end
    if (cmd_i.acc_en) begin
      col_mem[idx_q] <= acc_d;
    end
  end

  assign acc_d = first_q ? SUM_W'(pix_q) : rd_q + SUM_W'(pix_q);

  // rounded average: restoring divider, one quotient bit per step
  logic [2*PHW-1:0] prod;
  logic [CNTW-1:0]  cnt;
  logic [NUM_W-1:0] num_q;
  logic [CNTW-1:0]  rem_q;
  logic [SUM_W-1:0] acc_q;
  logic [CNTW:0]    trial;
  logic             ge;

  assign prod  = gw * gh;
  assign cnt   = prod[CNTW-1:0];
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, cnt};

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      acc_q <= acc_d;
      num_q <= {1'b0, acc_d} + NUM_W'(cnt >> 1);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? CNTW'(trial - {1'b0, cnt}) : trial[CNTW-1:0];
      num_q <= {num_q[NUM_W-2:0], ge};
    end
  end

  // output register
  logic [PIX_W-1:0] out_pixel_q;
  logic             out_last_q, out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_pixel_q <= sum_mode_q ? acc_q[PIX_W-1:0] : num_q[PIX_W-1:0];
      out_last_q  <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_pixel_o = out_pixel_q;
  assign out_last_o  = out_last_q;
  assign out_valid_o = out_valid_q;

  assign stat_o.in_range = in_range;
  assign stat_o.complete = complete_q;
  assign stat_o.sum_mode = sum_mode_q;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

endmodule

### design/image_box_binning.sv
`timescale 1ns / 1ps
// Box binning of a raster stream of 16-bit pixels. Each grid_width x grid_height block
// is summed into a line of column accumulators held in a single-port RAM with a
// registered read; the bottom-right pixel of a block yields one output pixel, either the
// sum wrapped to 16 bits or the rounded average. One transaction is processed at a time:
// a pixel outside the binning window only moves the position counters, an accumulating
// pixel takes a RAM read, then add and write back, and a block-completing pixel then loads
// the output; in average mode a restoring divider first produces one of 25 quotient bits
// per cycle. The output register lets the next transaction enter while a result waits.
module image_box_binning
  import ibb_pkg::*;
#(
  parameter int MaxSrcWidth = MAX_SRC_WIDTH,
  parameter int MaxOutWidth = MAX_OUT_WIDTH,
  parameter int MaxGrid     = MAX_GRID
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [PIX_W-1:0]   pixel_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PIX_W-1:0]   out_pixel_o,
  output logic               out_last_o
);

  ibb_cmd_t  cmd;
  ibb_stat_t stat;

  assign pready = 1'b1;

  ibb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  ibb_datapath #(
    .MaxSrcWidth (MaxSrcWidth),
    .MaxOutWidth (MaxOutWidth),
    .MaxGrid     (MaxGrid)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .out_stall_i   (out_stall_i),
    .out_pixel_o   (out_pixel_o),
    .out_last_o    (out_last_o),
    .out_valid_o   (out_valid_o),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule
